// ----- src/lpbm_pkg.sv -----
// lpbm_pkg: operation, status and sequencer state types for the page buffer manager
// no dependencies
`timescale 1ns / 1ps
package lpbm_pkg;

    typedef enum logic [2:0] {
        OP_FIX   = 3'd0,
        OP_UNFIX = 3'd1,
        OP_SET   = 3'd2,
        OP_CLR   = 3'd3,
        OP_FLUSH = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PINNED   = 2'd1,
        ST_NOT_RES  = 2'd2,
        ST_UNMAPPED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_LIST_POS,
        S_SHIFT,
        S_VICTIM,
        S_FLUSH,
        S_FLUSH_EMIT,
        S_OUT
    } state_t;

endpackage

// ----- src/lru_page_buffer_manager.sv -----
// lru_page_buffer_manager: frame metadata, recency list and scan sequencer
// depends on lpbm_pkg
//
// channel  dir  handshake        payload
// in       in   in_valid/ready   op, page_number, frame_index
// out      out  out_valid/ready  frame_out .. last
//
// one transaction at a time; a fix scans the tags, then finds a hit frame in the recency list
// or takes a free frame or an unpinned victim, then shifts the list one entry per cycle
// a flush walks the list, one entry per cycle, stalling while a writeback waits on out_ready
// all scans share one index counter; reset clears valid, pin and dirty at once
`timescale 1ns / 1ps
module lru_page_buffer_manager
    import lpbm_pkg::*;
#(
    parameter int FRAMES    = 32,
    parameter int PAGE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] page_number,
    input  logic [4:0]  frame_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  frame_out,
    output logic        hit,
    output logic        fetch_needed,
    output logic        writeback,
    output logic [15:0] writeback_page,
    output logic [1:0]  status,
    output logic [5:0]  free_frames,
    output logic        last
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] tag_mem [FRAMES];
    logic [IW-1:0]        order_mem [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    dirty_reg;
    logic [7:0]           pin_reg [FRAMES];
    logic [CW-1:0]        count_reg;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [4:0]           fidx_reg;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        frame_reg, frame_next;
    logic                 flush_any_reg, flush_any_next;

    logic [4:0]           o_frame_reg, o_frame_next;
    logic                 o_hit_reg, o_hit_next;
    logic                 o_fetch_reg, o_fetch_next;
    logic                 o_wb_reg, o_wb_next;
    logic [15:0]          o_wbp_reg, o_wbp_next;
    logic [1:0]           o_status_reg, o_status_next;
    logic                 o_last_reg, o_last_next;
    logic                 o_valid_reg, o_valid_next;

    // datapath control
    logic                 tag_we;
    logic                 ord_we;
    logic [IW-1:0]        ord_waddr;
    logic [IW-1:0]        ord_wdata;
    logic                 inc_count;
    logic                 pin_inc, pin_dec, pin_set1;
    logic                 dirty_we;
    logic                 val_set;
    logic [IW-1:0]        mod_frame;
    logic [IW-1:0]        dirty_frame;

    logic [IW-1:0]        idx_i;
    logic [IW-1:0]        ord_rd;
    logic [IW-1:0]        ord_prev;
    logic [IW-1:0]        first_free;
    logic                 any_free;
    logic                 fidx_ok;
    logic [FRAMES-1:0]    fidx_dec;

    assign idx_i    = idx_reg[IW-1:0];
    assign ord_rd   = order_mem[idx_i];
    assign ord_prev = order_mem[idx_i - IW'(1)];
    assign fidx_ok  = ({27'd0, fidx_reg} < 32'(FRAMES)) && valid_reg[fidx_reg[IW-1:0]];

    always_comb
    begin
        first_free = '0;
        any_free   = 1'b0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                first_free = IW'(i);
                any_free   = 1'b1;
            end
        end
        fidx_dec = '0;
        fidx_dec[fidx_reg[IW-1:0]] = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        flush_any_next = flush_any_reg;
        o_frame_next   = o_frame_reg;
        o_hit_next     = o_hit_reg;
        o_fetch_next   = o_fetch_reg;
        o_wb_next      = o_wb_reg;
        o_wbp_next     = o_wbp_reg;
        o_status_next  = o_status_reg;
        o_last_next    = o_last_reg;
        o_valid_next   = o_valid_reg;
        tag_we    = 1'b0;
        ord_we    = 1'b0;
        ord_waddr = idx_i;
        ord_wdata = ord_prev;
        inc_count = 1'b0;
        pin_inc   = 1'b0;
        pin_dec   = 1'b0;
        pin_set1  = 1'b0;
        dirty_we  = 1'b0;
        val_set   = 1'b0;
        mod_frame = frame_reg;
        dirty_frame = fidx_reg[IW-1:0];
        in_ready  = 1'b0;

        if (o_valid_reg && out_ready)
            o_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = !o_valid_reg || out_ready;
            end
            S_FIND:
            begin
                if (valid_reg[idx_i] && tag_mem[idx_i] == page_reg)
                begin
                    frame_next = idx_i;
                end
                if (idx_reg == CW'(FRAMES - 1) ||
                    (valid_reg[idx_i] && tag_mem[idx_i] == page_reg))
                begin
                    o_hit_next = 1'b0; o_fetch_next = 1'b0; o_wb_next = 1'b0;
                    o_wbp_next = '0; o_last_next = 1'b1; o_status_next = ST_OK;
                    o_frame_next = '0;
                    if (op_reg == OP_UNFIX)
                    begin
                        if (valid_reg[idx_i] && tag_mem[idx_i] == page_reg)
                        begin
                            pin_dec = 1'b1;
                            mod_frame = idx_i;
                            o_frame_next = 5'(idx_i);
                        end
                        else
                            o_status_next = ST_NOT_RES;
                        state_next = S_OUT;
                    end
                    else if (valid_reg[idx_i] && tag_mem[idx_i] == page_reg)
                    begin
                        pin_inc = 1'b1;
                        mod_frame = idx_i;
                        idx_next = '0;
                        state_next = S_LIST_POS;
                    end
                    else if (any_free)
                    begin
                        frame_next = first_free;
                        idx_next = count_reg;
                        state_next = S_SHIFT;
                        tag_we = 1'b1;
                        mod_frame = first_free;
                        pin_set1 = 1'b1;
                        val_set = 1'b1;
                        dirty_we = 1'b1;
                        dirty_frame = first_free;
                        inc_count = 1'b1;
                        o_frame_next = 5'(first_free);
                        o_fetch_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = CW'(FRAMES - 1);
                        state_next = S_VICTIM;
                    end
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_LIST_POS:
            begin
                if (ord_rd == frame_reg)
                begin
                    state_next = S_SHIFT;
                    o_frame_next = 5'(frame_reg);
                    o_hit_next = 1'b1;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_VICTIM:
            begin
                if (pin_reg[ord_rd] == 8'd0)
                begin
                    frame_next = ord_rd;
                    mod_frame = ord_rd;
                    o_frame_next = 5'(ord_rd);
                    o_fetch_next = 1'b1;
                    o_wb_next = dirty_reg[ord_rd];
                    o_wbp_next = dirty_reg[ord_rd] ? 16'(tag_mem[ord_rd]) : 16'd0;
                    tag_we = 1'b1;
                    pin_set1 = 1'b1;
                    dirty_we = 1'b1;
                    dirty_frame = ord_rd;
                    state_next = S_SHIFT;
                end
                else if (idx_reg == '0)
                begin
                    o_status_next = ST_PINNED;
                    state_next = S_OUT;
                end
                else
                    idx_next = idx_reg - CW'(1);
            end
            S_SHIFT:
            begin
                ord_we = 1'b1;
                if (idx_reg == '0)
                begin
                    ord_wdata = frame_reg;
                    state_next = S_OUT;
                end
                else
                    idx_next = idx_reg - CW'(1);
            end
            S_FLUSH:
            begin
                if (idx_reg == count_reg)
                begin
                    if (!flush_any_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_IDLE;
                end
                else if (dirty_reg[ord_rd])
                begin
                    if (!o_valid_reg || out_ready)
                    begin
                        frame_next = ord_rd;
                        state_next = S_FLUSH_EMIT;
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_FLUSH_EMIT:
            begin
                // look ahead for another dirty entry to set last
                if (idx_reg == count_reg || dirty_reg[ord_rd])
                begin
                    o_valid_next  = 1'b1;
                    o_frame_next  = 5'(frame_reg);
                    o_hit_next    = 1'b0;
                    o_fetch_next  = 1'b0;
                    o_wb_next     = 1'b1;
                    o_wbp_next    = 16'(tag_mem[frame_reg]);
                    o_status_next = ST_OK;
                    o_last_next   = (idx_reg == count_reg);
                    flush_any_next = 1'b1;
                    state_next    = S_FLUSH;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_OUT:
            begin
                o_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (in_valid && in_ready)
        begin
            o_frame_next = '0; o_hit_next = 1'b0; o_fetch_next = 1'b0;
            o_wb_next = 1'b0; o_wbp_next = '0; o_status_next = ST_OK;
            o_last_next = 1'b1;
            flush_any_next = 1'b0;
            idx_next = '0;
            case (op_t'(op))
                OP_FIX, OP_UNFIX: state_next = S_FIND;
                OP_SET, OP_CLR:
                begin
                    o_frame_next = frame_index;
                    state_next = S_OUT;
                end
                OP_FLUSH: state_next = S_FLUSH;
                default: state_next = S_OUT;
            endcase
        end
    end

    // set/clear is handled in S_OUT, the state entered on acceptance
    logic sc_do;
    assign sc_do = (state_reg == S_OUT) && (op_reg == OP_SET || op_reg == OP_CLR);

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[mod_frame] <= page_reg;
        if (ord_we)
            order_mem[ord_waddr] <= ord_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
                pin_reg[i] <= 8'd0;
            state_reg <= S_IDLE;
            idx_reg <= '0;
            frame_reg <= '0;
            flush_any_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            op_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            frame_reg <= frame_next;
            flush_any_reg <= flush_any_next;
            o_valid_reg <= o_valid_next;
            if (in_valid && in_ready)
                op_reg <= op;
            if (inc_count)
                count_reg <= count_reg + CW'(1);
            if (val_set)
                valid_reg[mod_frame] <= 1'b1;
            if (pin_set1)
                pin_reg[mod_frame] <= 8'd1;
            else if (pin_inc && pin_reg[mod_frame] != 8'hFF)
                pin_reg[mod_frame] <= pin_reg[mod_frame] + 8'd1;
            else if (pin_dec && pin_reg[mod_frame] != 8'd0)
                pin_reg[mod_frame] <= pin_reg[mod_frame] - 8'd1;
            if (dirty_we)
                dirty_reg[dirty_frame] <= 1'b0;
            if (sc_do)
            begin
                if (fidx_ok)
                begin
                    if (op_reg == OP_SET)
                        dirty_reg <= dirty_reg | fidx_dec;
                    else
                        dirty_reg <= dirty_reg & ~fidx_dec;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            page_reg <= PAGE_BITS'(page_number);
            fidx_reg <= frame_index;
        end
        o_frame_reg <= o_frame_next;
        o_hit_reg <= o_hit_next;
        o_fetch_reg <= o_fetch_next;
        o_wb_reg <= o_wb_next;
        o_wbp_reg <= o_wbp_next;
        o_last_reg <= o_last_next;
        if (sc_do && !fidx_ok)
            o_status_reg <= ST_UNMAPPED;
        else
            o_status_reg <= o_status_next;
    end

    assign out_valid      = o_valid_reg;
    assign frame_out      = o_frame_reg;
    assign hit            = o_hit_reg;
    assign fetch_needed   = o_fetch_reg;
    assign writeback      = o_wb_reg;
    assign writeback_page = o_wbp_reg;
    assign status         = o_status_reg;
    assign free_frames    = 6'(FRAMES) - 6'(count_reg);
    assign last           = o_last_reg;

endmodule
